[hdl/bldc_pkg.sv]
// Package: shared types, codes, constants and the commutation pattern table.
package bldc_pkg;

    // Event codes of an input item
    typedef enum logic [1:0] {
        OP_HALL    = 2'd0,
        OP_CURRENT = 2'd1,
        OP_TICK    = 2'd2,
        OP_COMMAND = 2'd3
    } t_op;

    // Status codes of a result item
    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_OVERCUR = 2'd1,
        ST_NOCMD   = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CURRENT_LIMIT = 2'd0,
        CFG_SPEED_MIN     = 2'd1,
        CFG_EDGE_RATE_MIN = 2'd2,
        CFG_RAMP_INC      = 2'd3
    } t_cfg_index;

    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 16;

    // Command byte decoding
    localparam logic [7:0] CmdStop  = 8'd101;
    localparam logic [7:0] CmdLimit = 8'd102;
    localparam logic [7:0] CmdBase  = 8'd100;
    localparam logic [2:0] TimeoutTicks = 3'd4;
    localparam logic [15:0] EdgeCountMax = 16'hFFFF;

    // Reset values of the configuration registers
    localparam logic [9:0] CurrentLimitReset = 10'd1023;
    localparam logic [7:0] RampIncReset      = 8'd1;

    // Configuration values as seen by the control core
    typedef struct packed {
        logic [9:0]  current_limit;
        logic [7:0]  speed_minimum;
        logic [15:0] edge_rate_minimum;
        logic [7:0]  ramp_increment;
    } t_cfg;

    // One registered input item
    typedef struct packed {
        t_op         op;
        logic [2:0]  hall_code;
        logic [9:0]  current_sample;
        logic [7:0]  command_byte;
    } t_item;

    // Six-step switch pattern for a hall code; invalid codes switch all off
    function automatic logic [15:0] phase_pattern(input logic [2:0] code);
        logic [15:0] pat;
        case (code)
            3'd1:    pat = 16'h0210;
            3'd2:    pat = 16'h2004;
            3'd3:    pat = 16'h0204;
            3'd4:    pat = 16'h0801;
            3'd5:    pat = 16'h0810;
            3'd6:    pat = 16'h2001;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

endpackage

[hdl/bldc_if.sv]
// Interfaces: input item, result item and configuration write channels.
interface bldc_in_if
    import bldc_pkg::*;
();
    logic       valid;
    logic       ready;
    t_op        op;
    logic [2:0] hall_code;
    logic [9:0] current_sample;
    logic [7:0] command_byte;

    modport source (output valid, op, hall_code, current_sample, command_byte, input ready);
    modport sink   (input valid, op, hall_code, current_sample, command_byte, output ready);
endinterface

interface bldc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  duty;
    logic [15:0] phase_override;
    logic [1:0]  status;
    logic        closed_loop;

    modport source (output valid, duty, phase_override, status, closed_loop, input ready);
    modport sink   (input valid, duty, phase_override, status, closed_loop, output ready);
endinterface

interface bldc_cfg_if
    import bldc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/bldc_cfg_regs.sv]
// Configuration register file written through the configuration channel.
module bldc_cfg_regs
    import bldc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    bldc_cfg_if.sink       i_cfg,
    output t_cfg           o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_limit     <= CurrentLimitReset;
            r_cfg.speed_minimum     <= '0;
            r_cfg.edge_rate_minimum <= '0;
            r_cfg.ramp_increment    <= RampIncReset;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_CURRENT_LIMIT: r_cfg.current_limit     <= i_cfg.data[9:0];
                CFG_SPEED_MIN:     r_cfg.speed_minimum     <= i_cfg.data[7:0];
                CFG_EDGE_RATE_MIN: r_cfg.edge_rate_minimum <= i_cfg.data;
                CFG_RAMP_INC:      r_cfg.ramp_increment    <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[hdl/bldc_in_stage.sv]
// Input register: captures one item and holds it until the core takes it.
module bldc_in_stage
    import bldc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    bldc_in_if.sink  i_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_item    o_item
);

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held item leaves this cycle
    assign i_item.ready = !r_valid || i_take;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    // Capture the payload of an accepted item
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.op             <= i_item.op;
            r_item.hall_code      <= i_item.hall_code;
            r_item.current_sample <= i_item.current_sample;
            r_item.command_byte   <= i_item.command_byte;
        end
    end

endmodule

[hdl/bldc_core.sv]
// Control core: applies one item to the motor state; the state is the result register.
module bldc_core
    import bldc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_take,
    bldc_out_if.source o_result
);

    logic        r_out_valid;
    logic [9:0]  r_last_current;
    logic [15:0] r_edge_count;
    logic [7:0]  r_speed_command;
    logic [2:0]  r_timeout_left;
    logic [2:0]  r_ramp_index;
    logic        r_mode_closed;
    t_status     r_status;
    logic [7:0]  r_duty;
    logic [15:0] r_override;

    logic [9:0]  n_last_current;
    logic [15:0] n_edge_count;
    logic [7:0]  n_speed_command;
    logic [2:0]  n_timeout_left;
    logic [2:0]  n_ramp_index;
    logic        n_mode_closed;
    t_status     n_status;
    logic [7:0]  n_duty;
    logic [15:0] n_override;

    // Take an item when the result slot is empty or being emptied
    assign o_take = i_valid && (!r_out_valid || o_result.ready);

    assign o_result.valid          = r_out_valid;
    assign o_result.duty           = r_duty;
    assign o_result.phase_override = r_override;
    assign o_result.status         = r_status;
    assign o_result.closed_loop    = r_mode_closed;

    // Next state for the held item
    always_comb begin
        n_last_current  = r_last_current;
        n_edge_count    = r_edge_count;
        n_speed_command = r_speed_command;
        n_timeout_left  = r_timeout_left;
        n_ramp_index    = r_ramp_index;
        n_mode_closed   = r_mode_closed;
        n_status        = r_status;
        n_duty          = r_duty;
        n_override      = r_override;
        case (i_item.op)
            OP_HALL: begin
                if (r_mode_closed) begin
                    n_override = phase_pattern(i_item.hall_code);
                end
                if (r_edge_count != EdgeCountMax) begin
                    n_edge_count = r_edge_count + 16'd1;
                end
            end
            OP_CURRENT: begin
                n_last_current = i_item.current_sample;
            end
            OP_TICK: begin
                n_edge_count = '0;
                if (r_last_current > i_cfg.current_limit) begin
                    // Overcurrent trip
                    n_duty   = '0;
                    n_status = ST_OVERCUR;
                end else if (r_timeout_left != '0) begin
                    n_duty   = '0;
                    n_status = ST_RUN;
                    n_timeout_left = r_timeout_left - 3'd1;
                    if (r_speed_command > i_cfg.speed_minimum) begin
                        if (r_edge_count > i_cfg.edge_rate_minimum) begin
                            // Hall edges fast enough: follow the sensors
                            n_duty        = r_speed_command;
                            n_mode_closed = 1'b1;
                        end else begin
                            // Open-loop ramp with stepped patterns
                            n_mode_closed = 1'b0;
                            n_duty        = r_duty + i_cfg.ramp_increment;
                            n_override    = phase_pattern(r_ramp_index);
                            n_ramp_index  = r_ramp_index + 3'd1;
                        end
                    end
                end else begin
                    // Commands timed out: drop the drive
                    n_duty   = '0;
                    n_status = ST_NOCMD;
                end
            end
            OP_COMMAND: begin
                if (i_item.command_byte != '0 && i_item.command_byte < CmdLimit) begin
                    if (i_item.command_byte == CmdStop) begin
                        n_speed_command = '0;
                    end else begin
                        n_speed_command = {CmdBase[6:0] - i_item.command_byte[6:0], 1'b0};
                    end
                    n_timeout_left = TimeoutTicks;
                end
            end
            default: begin
            end
        endcase
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_result.ready) begin
            r_out_valid <= i_valid;
        end
    end

    // Motor state, which is also the result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_current  <= '0;
            r_edge_count    <= '0;
            r_speed_command <= '0;
            r_timeout_left  <= '0;
            r_ramp_index    <= '0;
            r_mode_closed   <= 1'b0;
            r_status        <= ST_RUN;
            r_duty          <= '0;
            r_override      <= '0;
        end else if (o_take) begin
            r_last_current  <= n_last_current;
            r_edge_count    <= n_edge_count;
            r_speed_command <= n_speed_command;
            r_timeout_left  <= n_timeout_left;
            r_ramp_index    <= n_ramp_index;
            r_mode_closed   <= n_mode_closed;
            r_status        <= n_status;
            r_duty          <= n_duty;
            r_override      <= n_override;
        end
    end

endmodule

[hdl/bldc_commutation_and_startup.sv]
// Items pass the input register, then the state/result register.
// Throughput: one item per cycle while results are taken; the input register and the
// state/result register form two stages, and while a result waits the input register
// takes one more item and then holds the input side off until the result is taken.
// Configuration writes take effect in the cycle after the write and are always ready.
// Reset (synchronous, active low) clears all motor state and loads register defaults.
module bldc_commutation_and_startup
    import bldc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bldc_in_if.sink    i_item,
    bldc_cfg_if.sink   i_cfg,
    bldc_out_if.source o_result
);

    t_cfg  w_cfg;
    t_item w_item;
    logic  w_item_valid;
    logic  w_take;

    // Configuration registers
    bldc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Input register
    bldc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    // Control core and result register
    bldc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_item_valid),
        .i_item   (w_item),
        .o_take   (w_take),
        .o_result (o_result)
    );

endmodule

[bench/bldc_motor_checker.sv]
// Checker: predicts each result item of the motor controller and compares it with the block.
`timescale 1ns / 1ps

module bldc_motor_checker
    import bldc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bldc_in_if   i_item,
    bldc_cfg_if  i_cfg,
    bldc_out_if  i_result,
    output int   o_mismatch_count,
    output int   o_pending_count
);

    typedef struct packed {
        logic [7:0]  duty;
        logic [15:0] phase_override;
        t_status     status;
        logic        closed_loop;
    } t_motor_result;

    // Switch patterns, hall code 7 in the top slice down to code 0 at the bottom
    localparam logic [127:0] SwitchPatterns = {
        16'h0000, 16'h2001, 16'h0810, 16'h0801,
        16'h0204, 16'h2004, 16'h0210, 16'h0000
    };

    localparam int ReportLimit = 10;

    // Predicted motor state and register copies
    t_cfg        cfg;
    logic [9:0]  last_current;
    logic [15:0] edge_count;
    logic [7:0]  speed_command;
    logic [2:0]  timeout_left;
    logic [2:0]  ramp_index;
    logic        mode_closed;
    t_status     status_q;
    logic [7:0]  duty_q;
    logic [15:0] override_q;

    t_motor_result expected_results[$];
    int            mismatches = 0;

    assign o_mismatch_count = mismatches;

    task automatic clear_motor_state();
        cfg.current_limit     = CurrentLimitReset;
        cfg.speed_minimum     = '0;
        cfg.edge_rate_minimum = '0;
        cfg.ramp_increment    = RampIncReset;
        last_current  = '0;
        edge_count    = '0;
        speed_command = '0;
        timeout_left  = '0;
        ramp_index    = '0;
        mode_closed   = 1'b0;
        status_q      = ST_RUN;
        duty_q        = '0;
        override_q    = '0;
    endtask

    // Trip, time out, ramp open loop or run closed loop; always clear the edge count
    task automatic run_control_tick();
        logic [7:0] next_duty;
        next_duty = '0;
        if (last_current > cfg.current_limit) begin
            duty_q   = '0;
            status_q = ST_OVERCUR;
        end else if (timeout_left != 0) begin
            if (speed_command > cfg.speed_minimum) begin
                if (edge_count > cfg.edge_rate_minimum) begin
                    next_duty   = speed_command;
                    mode_closed = 1'b1;
                end else begin
                    mode_closed = 1'b0;
                    next_duty   = duty_q + cfg.ramp_increment;
                    override_q  = SwitchPatterns[{ramp_index, 4'b0000} +: 16];
                    ramp_index  = ramp_index + 3'd1;
                end
            end
            timeout_left = timeout_left - 3'd1;
            status_q     = ST_RUN;
            duty_q       = next_duty;
        end else begin
            duty_q   = '0;
            status_q = ST_NOCMD;
        end
        edge_count = '0;
    endtask

    task automatic apply_motor_event(input t_item ev, output t_motor_result res);
        case (ev.op)
            OP_HALL: begin
                if (mode_closed)
                    override_q = SwitchPatterns[{ev.hall_code, 4'b0000} +: 16];
                if (edge_count != EdgeCountMax)
                    edge_count = edge_count + 16'd1;
            end
            OP_CURRENT: last_current = ev.current_sample;
            OP_TICK:    run_control_tick();
            OP_COMMAND: begin
                if (ev.command_byte != 0 && ev.command_byte < CmdLimit) begin
                    if (ev.command_byte == CmdStop)
                        speed_command = '0;
                    else
                        speed_command = (CmdBase - ev.command_byte) << 1;
                    timeout_left = TimeoutTicks;
                end
            end
            default: ;
        endcase
        res.duty           = duty_q;
        res.phase_override = override_q;
        res.status         = status_q;
        res.closed_loop    = mode_closed;
    endtask

    // Watch all three channels at the rising edge
    always @(posedge i_clk) begin
        t_item         ev;
        t_motor_result want;
        if (!i_rst_n) begin
            clear_motor_state();
            expected_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_index'(i_cfg.index))
                    CFG_CURRENT_LIMIT: cfg.current_limit     = i_cfg.data[9:0];
                    CFG_SPEED_MIN:     cfg.speed_minimum     = i_cfg.data[7:0];
                    CFG_EDGE_RATE_MIN: cfg.edge_rate_minimum = i_cfg.data[15:0];
                    CFG_RAMP_INC:      cfg.ramp_increment    = i_cfg.data[7:0];
                    default: ;
                endcase
            end
            // Compare a delivered item against the oldest prediction
            if (i_result.valid && i_result.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= ReportLimit)
                        $display("%0t: result item with nothing expected: duty %0d override %h",
                                 $realtime, i_result.duty, i_result.phase_override);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.duty !== want.duty
                            || i_result.phase_override !== want.phase_override
                            || i_result.status !== want.status
                            || i_result.closed_loop !== want.closed_loop) begin
                        mismatches++;
                        if (mismatches <= ReportLimit)
                            $display({"%0t: mismatch: expected duty %0d override %h status %0d",
                                      " closed %0b, got duty %0d override %h status %0d",
                                      " closed %0b"},
                                     $realtime, want.duty, want.phase_override, want.status,
                                     want.closed_loop, i_result.duty, i_result.phase_override,
                                     i_result.status, i_result.closed_loop);
                    end
                end
            end
            // Predict the result of each accepted item
            if (i_item.valid && i_item.ready) begin
                ev.op             = i_item.op;
                ev.hall_code      = i_item.hall_code;
                ev.current_sample = i_item.current_sample;
                ev.command_byte   = i_item.command_byte;
                apply_motor_event(ev, want);
                expected_results.push_back(want);
            end
        end
        o_pending_count <= expected_results.size();
    end

endmodule

[bench/bldc_commutation_and_startup_tb.sv]
// Testbench top: drives events and register writes into the motor controller and gives the verdict.
`timescale 1ns / 1ps

module bldc_commutation_and_startup_tb;
    import bldc_pkg::*;

    localparam int RunCycleLimit = 1_000_000;
    localparam int LongHoldCycles = 120;

    logic clk;
    logic rst_n;

    bldc_in_if  in_ch ();
    bldc_cfg_if cfg_ch ();
    bldc_out_if out_ch ();

    int          mismatch_count;
    int          pending_count;
    int          cycle_count = 0;
    int unsigned events_sent = 0;
    int unsigned burst_left  = 0;
    int unsigned limit_setting = CurrentLimitReset;
    bit          hold_armed = 1'b0;

    bldc_commutation_and_startup i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (in_ch),
        .i_cfg    (cfg_ch),
        .o_result (out_ch)
    );

    bldc_motor_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_item           (in_ch),
        .i_cfg            (cfg_ch),
        .i_result         (out_ch),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RunCycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one event item; fields the event does not use carry random bits
    task automatic offer_event(input t_op op, input logic [31:0] value);
        in_ch.valid          = 1'b1;
        in_ch.op             = op;
        in_ch.hall_code      = (op == OP_HALL) ? value[2:0] : 3'($urandom);
        in_ch.current_sample = (op == OP_CURRENT) ? value[9:0] : 10'($urandom);
        in_ch.command_byte   = (op == OP_COMMAND) ? value[7:0] : 8'($urandom);
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        events_sent++;
        // Close the burst with a random gap
        if (burst_left == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    // Hold input valid low until every prediction has been matched
    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [15:0] value);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [9:0] limit, input logic [7:0] speed_min,
                                 input logic [15:0] edge_min, input logic [7:0] ramp_inc);
        drain_results();
        cfg_ch.valid = 1'b1;
        write_register(CFG_CURRENT_LIMIT, 16'(limit));
        write_register(CFG_SPEED_MIN, 16'(speed_min));
        write_register(CFG_EDGE_RATE_MIN, edge_min);
        write_register(CFG_RAMP_INC, 16'(ramp_inc));
        cfg_ch.valid  = 1'b0;
        limit_setting = limit;
    endtask

    // Mostly command, edges, samples and ticks in order; some noise and stray commands
    task automatic run_random_phase(input int unsigned item_goal);
        int unsigned start;
        start = events_sent;
        while (events_sent - start < item_goal) begin
            case ($urandom_range(0, 9))
                0: offer_event(t_op'($urandom_range(0, 3)), $urandom);
                1: offer_event(OP_COMMAND, $urandom_range(0, 255));
                default: begin
                    offer_event(OP_COMMAND, $urandom_range(1, 101));
                    repeat ($urandom_range(1, 6)) begin
                        repeat ($urandom_range(0, 8)) offer_event(OP_HALL, $urandom_range(0, 7));
                        if ($urandom_range(0, 3) == 0)
                            offer_event(OP_CURRENT, $urandom_range(0, 1)
                                                    ? $urandom_range(0, limit_setting)
                                                    : $urandom_range(0, 1023));
                        offer_event(OP_TICK, 0);
                    end
                end
            endcase
        end
    endtask

    // Result side: random stall pattern, plus one long hold-off once armed
    initial begin
        int unsigned mode;
        bit          hold_done;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_armed && !hold_done) begin
                out_ch.ready = 1'b0;
                repeat (LongHoldCycles) @(negedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 60)) begin
                case (mode)
                    0:       out_ch.ready = 1'b1;
                    1:       out_ch.ready = ($urandom_range(0, 3) != 0);
                    default: out_ch.ready = $urandom_range(0, 1);
                endcase
                @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        in_ch.valid          = 1'b0;
        in_ch.op             = OP_HALL;
        in_ch.hall_code      = '0;
        in_ch.current_sample = '0;
        in_ch.command_byte   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_CURRENT_LIMIT;
        cfg_ch.data          = '0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: default registers, no command yet
        offer_event(OP_TICK, 0);
        offer_event(OP_COMMAND, 0);
        offer_event(OP_COMMAND, 255);
        offer_event(OP_COMMAND, 102);
        offer_event(OP_COMMAND, 1);
        // Two ramp steps, then an edge lets the next tick go closed loop
        offer_event(OP_TICK, 0);
        offer_event(OP_TICK, 0);
        offer_event(OP_HALL, 3);
        offer_event(OP_TICK, 0);
        // Every hall code in closed loop, invalid codes included
        for (int code = 0; code < 8; code++) offer_event(OP_HALL, code);
        offer_event(OP_CURRENT, 1023);
        offer_event(OP_CURRENT, 0);
        // Zero speed and stop command, then run the timeout out
        offer_event(OP_COMMAND, 100);
        offer_event(OP_TICK, 0);
        offer_event(OP_COMMAND, 101);
        repeat (5) offer_event(OP_TICK, 0);

        // Random phases over several register settings
        apply_setting(10'd0, 8'd0, 16'd0, 8'd255);
        hold_armed = 1'b1;
        run_random_phase(300);
        apply_setting(10'd1023, 8'd255, 16'hFFFF, 8'd0);
        run_random_phase(300);
        apply_setting(10'd512, 8'd100, 16'd3, 8'd17);
        run_random_phase(300);
        repeat (2) begin
            apply_setting(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 8)), 8'($urandom_range(0, 255)));
            run_random_phase(300);
        end
        apply_setting(10'd700, 8'd0, 16'd1, 8'd128);
        run_random_phase(300);

        // Edge rate threshold: hall edges up to the minimum edge rate, then past it, each closed by a tick
        apply_setting(10'd1023, 8'd0, 16'd3, 8'd1);
        offer_event(OP_CURRENT, 0);
        offer_event(OP_COMMAND, 50);
        repeat (3) offer_event(OP_HALL, $urandom_range(0, 7));
        offer_event(OP_TICK, 0);
        repeat (4) offer_event(OP_HALL, $urandom_range(0, 7));
        offer_event(OP_TICK, 0);

        drain_results();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/bldc_pkg.sv
hdl/bldc_if.sv
hdl/bldc_cfg_regs.sv
hdl/bldc_in_stage.sv
hdl/bldc_core.sv
hdl/bldc_commutation_and_startup.sv
bench/bldc_motor_checker.sv
bench/bldc_commutation_and_startup_tb.sv
